// File: sv/ray_triangle_nearest_hit_defines.svh
// Assertion macros for the ray/triangle nearest-hit block.
// Included by the top level; depends on nothing.
`ifndef RAY_TRIANGLE_NEAREST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_NEAREST_HIT_DEFINES_SVH

// a implies b on the same edge, reset aware
`define RTN_ASSERT_IMPL(label, rst_s, a, b) \
  label: assert property (@(posedge clk) disable iff (rst_s) (a) |-> (b)) \
    else $error("check failed");

// a implies b on the next edge
`define RTN_ASSERT_NEXT(label, rst_s, a, b) \
  label: assert property (@(posedge clk) disable iff (rst_s) (a) |=> (b)) \
    else $error("check failed");

`endif

// File: sv/rtn_pkg.sv
// Shared types and constants for the ray/triangle nearest-hit block.
// No dependencies.
package rtn_pkg;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
    logic [15:0]        tri_face;
    logic               last_tri;
  } tri_in_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] nearest_distance;
  } hit_out_t;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_FACE_SEL = 3'd6;
  localparam logic [2:0] REG_FACE_MOD = 3'd7;

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    begin
      if (x > 34'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (x < -34'sd2147483648) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
    end
  endfunction

endpackage

// File: sv/rtn_divider.sv
// Restoring divider, one quotient bit per cycle: q = floor(num / den).
// Does not use rtn_pkg; operands are unsigned.
module rtn_divider #(
  parameter int NUM_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [31:0]         den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [32:0]         rem;
  logic [NUM_BITS-1:0] sh;
  logic [31:0]         d;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [32:0]         trial;
  logic [33:0]         diff;

  always_comb begin
    trial = {rem[31:0], sh[NUM_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, d};
  end

  // one bit per cycle, MSB first
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      sh   <= num;
      d    <= den;
      cnt  <= CNT_BITS'(NUM_BITS);
      quo  <= '0;
    end else if (busy) begin
      sh <= {sh[NUM_BITS-2:0], 1'b0};
      if (!diff[33]) begin
        rem <= diff[32:0];
        quo <= {quo[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// File: sv/ray_triangle_nearest_hit.sv
// Ray versus triangle stream, nearest hit, top level; uses rtn_pkg, rtn_divider.
// Counted triangle from accept to in_ready: setup, 24 multiply steps, check,
// divide, final; skipped ones go from setup to final, parallel ones leave
// after det, rejected ones skip the divide. Result held until taken; one item
// in flight at a time. Reset (synchronous, rst high) clears config and state.
`include "ray_triangle_nearest_hit_defines.svh"
module ray_triangle_nearest_hit #(
  parameter int FRAC_BITS    = 16,
  parameter int FACE_ID_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rtn_pkg::tri_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rtn_pkg::hit_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import rtn_pkg::*;

  localparam int FID = (FACE_ID_BITS < 16) ? FACE_ID_BITS : 16;
  localparam longint TOL_L = ((64'sd1 <<< FRAC_BITS) + 999999) / 1000000;
  localparam logic signed [31:0] TOL = 32'(TOL_L);
  localparam int DIV_BITS = 32 + FRAC_BITS;
  // three shifted 32x32 products summed without overflow
  localparam int ACC_BITS = 66 - FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] ACC_HI = ACC_BITS'(64'sd2147483647);
  localparam logic signed [ACC_BITS-1:0] ACC_LO = ACC_BITS'(-64'sd2147483648);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MAC, S_CHECK, S_DIV, S_FINAL,
                            S_OUT} state_t;

  // configuration
  logic signed [31:0] org [3];
  logic signed [17:0] dir [3];
  logic [15:0]        face_select;
  logic               face_mode;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= 18'sd65536;
      face_select <= '0;
      face_mode   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_DIR_X:    dir[0] <= cfg_data[17:0];
        REG_DIR_Y:    dir[1] <= cfg_data[17:0];
        REG_DIR_Z:    dir[2] <= cfg_data[17:0];
        REG_FACE_SEL: face_select <= cfg_data[15:0];
        REG_FACE_MOD: face_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // working registers: e1, e2, s, h, q, dets
  state_t                    state;
  logic signed [31:0]        e1 [3];
  logic signed [31:0]        e2 [3];
  logic signed [31:0]        sv [3];
  logic signed [31:0]        h  [3];
  logic signed [31:0]        q  [3];
  logic signed [31:0]        det, nu, nv, nt;
  logic signed [ACC_BITS-1:0] acc;
  logic [4:0]                step;
  logic                      counted, last;
  logic                      any_hit;
  logic [30:0]               best;
  tri_in_t                   tin;

  // operand select for the shared multiplier; step k of 24
  logic signed [31:0] ma, mb;
  logic               msub, mfirst, mlast;
  logic [3:0]         mdst;

  always_comb begin
    ma = '0; mb = '0; msub = 1'b0; mfirst = 1'b0; mlast = 1'b0; mdst = 4'd0;
    unique case (step)
      5'd0:  begin ma = 32'(dir[1]); mb = e2[2]; mfirst = 1'b1; end
      5'd1:  begin ma = 32'(dir[2]); mb = e2[1]; msub = 1'b1; mlast = 1'b1;
                   mdst = 4'd0; end
      5'd2:  begin ma = 32'(dir[2]); mb = e2[0]; mfirst = 1'b1; end
      5'd3:  begin ma = 32'(dir[0]); mb = e2[2]; msub = 1'b1; mlast = 1'b1;
                   mdst = 4'd1; end
      5'd4:  begin ma = 32'(dir[0]); mb = e2[1]; mfirst = 1'b1; end
      5'd5:  begin ma = 32'(dir[1]); mb = e2[0]; msub = 1'b1; mlast = 1'b1;
                   mdst = 4'd2; end
      5'd6:  begin ma = e1[0]; mb = h[0]; mfirst = 1'b1; end
      5'd7:  begin ma = e1[1]; mb = h[1]; end
      5'd8:  begin ma = e1[2]; mb = h[2]; mlast = 1'b1; mdst = 4'd3; end
      5'd9:  begin ma = sv[0]; mb = h[0]; mfirst = 1'b1; end
      5'd10: begin ma = sv[1]; mb = h[1]; end
      5'd11: begin ma = sv[2]; mb = h[2]; mlast = 1'b1; mdst = 4'd4; end
      5'd12: begin ma = sv[1]; mb = e1[2]; mfirst = 1'b1; end
      5'd13: begin ma = sv[2]; mb = e1[1]; msub = 1'b1; mlast = 1'b1;
                   mdst = 4'd5; end
      5'd14: begin ma = sv[2]; mb = e1[0]; mfirst = 1'b1; end
      5'd15: begin ma = sv[0]; mb = e1[2]; msub = 1'b1; mlast = 1'b1;
                   mdst = 4'd6; end
      5'd16: begin ma = sv[0]; mb = e1[1]; mfirst = 1'b1; end
      5'd17: begin ma = sv[1]; mb = e1[0]; msub = 1'b1; mlast = 1'b1;
                   mdst = 4'd7; end
      5'd18: begin ma = 32'(dir[0]); mb = q[0]; mfirst = 1'b1; end
      5'd19: begin ma = 32'(dir[1]); mb = q[1]; end
      5'd20: begin ma = 32'(dir[2]); mb = q[2]; mlast = 1'b1; mdst = 4'd8; end
      5'd21: begin ma = e2[0]; mb = q[0]; mfirst = 1'b1; end
      5'd22: begin ma = e2[1]; mb = q[1]; end
      5'd23: begin ma = e2[2]; mb = q[2]; mlast = 1'b1; mdst = 4'd9; end
      default: ;
    endcase
  end

  // accumulator clamp to signed 32 bits
  function automatic logic signed [31:0] sat_acc(
      input logic signed [ACC_BITS-1:0] x);
    if (x > ACC_HI) return 32'sh7FFF_FFFF;
    if (x < ACC_LO) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // shared multiplier; arithmetic shift floors
  logic signed [63:0]         prod;
  logic signed [ACC_BITS-1:0] pshift, acc_in, acc_new;
  logic signed [31:0]         acc_sat;
  always_comb begin
    prod    = 64'(ma) * 64'(mb);
    pshift  = ACC_BITS'(prod >>> FRAC_BITS);
    acc_in  = mfirst ? '0 : acc;
    acc_new = msub ? acc_in - pshift : acc_in + pshift;
    acc_sat = sat_acc(acc_new);
  end

  // edge vectors
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return sat32(34'(a) - 34'(b));
  endfunction

  // sign fold and hit test
  logic signed [32:0] adet, anu, anv, ant;
  logic               fail;
  always_comb begin
    adet = det[31] ? -33'(det) : 33'(det);
    anu  = det[31] ? -33'(nu)  : 33'(nu);
    anv  = det[31] ? -33'(nv)  : 33'(nv);
    ant  = det[31] ? -33'(nt)  : 33'(nt);
    fail = anu < 0 || anu > adet || anv < 0 ||
           (34'(anu) + 34'(anv)) > 34'(adet) || ant <= 0;
  end

  logic                div_start, div_done;
  logic [DIV_BITS-1:0] div_num, div_quo;
  assign div_num = DIV_BITS'(ant[31:0]) << FRAC_BITS;

  rtn_divider #(.NUM_BITS(DIV_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(adet[31:0]), .done(div_done), .quo(div_quo)
  );

  logic [30:0] tq;
  assign tq = (div_quo > DIV_BITS'(DIST_MAX)) ? DIST_MAX : div_quo[30:0];

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign div_start = (state == S_CHECK) && !fail;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      any_hit <= 1'b0;
      best    <= DIST_MAX;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          tin     <= in_data;
          counted <= face_mode ==
                     (in_data.tri_face[FID-1:0] == face_select[FID-1:0]);
          last    <= in_data.last_tri;
          state   <= S_PREP;
        end
        S_PREP: begin
          e1[0] <= sub_sat(tin.v1_x, tin.v0_x);
          e1[1] <= sub_sat(tin.v1_y, tin.v0_y);
          e1[2] <= sub_sat(tin.v1_z, tin.v0_z);
          e2[0] <= sub_sat(tin.v2_x, tin.v0_x);
          e2[1] <= sub_sat(tin.v2_y, tin.v0_y);
          e2[2] <= sub_sat(tin.v2_z, tin.v0_z);
          sv[0] <= sub_sat(org[0], tin.v0_x);
          sv[1] <= sub_sat(org[1], tin.v0_y);
          sv[2] <= sub_sat(org[2], tin.v0_z);
          step  <= '0;
          state <= counted ? S_MAC : S_FINAL;
        end
        S_MAC: begin
          acc <= acc_new;
          if (mlast) begin
            unique case (mdst)
              4'd0: h[0] <= acc_sat;
              4'd1: h[1] <= acc_sat;
              4'd2: h[2] <= acc_sat;
              4'd3: det  <= acc_sat;
              4'd4: nu   <= acc_sat;
              4'd5: q[0] <= acc_sat;
              4'd6: q[1] <= acc_sat;
              4'd7: q[2] <= acc_sat;
              4'd8: nv   <= acc_sat;
              default: nt <= acc_sat;
            endcase
          end
          // parallel triangle: stop after det
          if (step == 5'd8 && acc_sat > -TOL && acc_sat < TOL)
            state <= S_FINAL;
          else if (step == 5'd23) state <= S_CHECK;
          step <= step + 1'b1;
        end
        S_CHECK: state <= fail ? S_FINAL : S_DIV;
        S_DIV: if (div_done) begin
          if (31'(tq) > 31'(TOL)) begin
            any_hit <= 1'b1;
            if (tq < best) best <= tq;
          end
          state <= S_FINAL;
        end
        S_FINAL: begin
          out_data.hit <= any_hit;
          out_data.nearest_distance <= any_hit ? best : DIST_MAX;
          if (last) begin
            any_hit <= 1'b0;
            best    <= DIST_MAX;
            state   <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `RTN_ASSERT_IMPL(a_no_miss_max, rst, out_valid && !out_data.hit,
                   out_data.nearest_distance == DIST_MAX)
  `RTN_ASSERT_NEXT(a_out_hold, rst, out_valid && !out_ready,
                   out_valid && $stable(out_data))
  `RTN_ASSERT_IMPL(a_busy_not_ready, rst, out_valid, !in_ready)
  `RTN_ASSERT_NEXT(a_accept_busy, rst, in_valid && in_ready, !in_ready)
endmodule

// File: sim/ray_triangle_nearest_hit_tb.sv
// Self-checking testbench for the ray/triangle nearest-hit block.
// Depends on rtn_pkg and ray_triangle_nearest_hit (with its divider).
`timescale 1ns / 1ps
module ray_triangle_nearest_hit_tb;
  import rtn_pkg::*;

  localparam logic MODE_SKIP = 1'b0;
  localparam logic MODE_ONLY = 1'b1;
  localparam longint UNIT = 65536;
  localparam longint HIT_TOL = 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tri_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hit_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // ray and face selection as the block should hold them
  longint ray_org [3];
  longint ray_dir [3];
  logic [15:0] sel_face;
  logic sel_mode;
  logic [30:0] best_dist;
  logic seen_hit;

  hit_out_t pending_hits [$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  ray_triangle_nearest_hit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_triangle_nearest_hit_tb NOT OK");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------- predictor ----------------
  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // product rounded toward minus infinity
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint dot(longint a [3], longint b [3]);
    return clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
  endfunction

  function automatic bit ray_hits(tri_in_t t, output logic [30:0] hit_dist);
    longint p0 [3], p1 [3], p2 [3];
    longint e1 [3], e2 [3], s [3], h [3], q [3];
    longint det, nu, nv, nt, tq;
    hit_dist = DIST_MAX;
    p0[0] = t.v0_x; p0[1] = t.v0_y; p0[2] = t.v0_z;
    p1[0] = t.v1_x; p1[1] = t.v1_y; p1[2] = t.v1_z;
    p2[0] = t.v2_x; p2[1] = t.v2_y; p2[2] = t.v2_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = clamp32(p1[i] - p0[i]);
      e2[i] = clamp32(p2[i] - p0[i]);
      s[i] = clamp32(ray_org[i] - p0[i]);
    end
    h[0] = clamp32(qmul(ray_dir[1], e2[2]) - qmul(ray_dir[2], e2[1]));
    h[1] = clamp32(qmul(ray_dir[2], e2[0]) - qmul(ray_dir[0], e2[2]));
    h[2] = clamp32(qmul(ray_dir[0], e2[1]) - qmul(ray_dir[1], e2[0]));
    det = dot(e1, h);
    if (det > -HIT_TOL && det < HIT_TOL) return 0;
    nu = dot(s, h);
    q[0] = clamp32(qmul(s[1], e1[2]) - qmul(s[2], e1[1]));
    q[1] = clamp32(qmul(s[2], e1[0]) - qmul(s[0], e1[2]));
    q[2] = clamp32(qmul(s[0], e1[1]) - qmul(s[1], e1[0]));
    nv = dot(ray_dir, q);
    nt = dot(e2, q);
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (nu < 0 || nu > det) return 0;
    if (nv < 0 || nu + nv > det) return 0;
    if (nt <= 0) return 0;
    tq = (nt <<< 16) / det;
    if (tq > 64'sd2147483647) tq = 64'sd2147483647;
    if (tq <= HIT_TOL) return 0;
    hit_dist = tq[30:0];
    return 1;
  endfunction

  // one accepted triangle: update hit state, queue a result on the last one
  function automatic void track_triangle(tri_in_t t);
    logic [30:0] d;
    bit same;
    bit counted;
    hit_out_t r;
    same = (t.tri_face == sel_face);
    counted = (sel_mode == MODE_ONLY) ? same : !same;
    if (counted && ray_hits(t, d)) begin
      seen_hit = 1;
      if (d < best_dist) best_dist = d;
    end
    if (t.last_tri) begin
      r.hit = seen_hit;
      r.nearest_distance = seen_hit ? best_dist : DIST_MAX;
      pending_hits.insert(pending_hits.size(), r);
      seen_hit = 0;
      best_dist = DIST_MAX;
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_tri(tri_in_t t);
    int g;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    track_triangle(t);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_org[0] = longint'($signed(val));
      REG_ORIGIN_Y: ray_org[1] = longint'($signed(val));
      REG_ORIGIN_Z: ray_org[2] = longint'($signed(val));
      REG_DIR_X:    ray_dir[0] = longint'($signed(val[17:0]));
      REG_DIR_Y:    ray_dir[1] = longint'($signed(val[17:0]));
      REG_DIR_Z:    ray_dir[2] = longint'($signed(val[17:0]));
      REG_FACE_SEL: sel_face = val[15:0];
      REG_FACE_MOD: sel_mode = val[0];
      default: ;
    endcase
  endtask

  // all results in and pipeline drained before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         longint dx, longint dy, longint dz,
                         logic [15:0] face, logic mode);
    drain();
    write_reg(REG_ORIGIN_X, ox[31:0]);
    write_reg(REG_ORIGIN_Y, oy[31:0]);
    write_reg(REG_ORIGIN_Z, oz[31:0]);
    // upper bits above the 18-bit field are junk on purpose
    write_reg(REG_DIR_X, {14'($urandom_range(0, 16383)), dx[17:0]});
    write_reg(REG_DIR_Y, {14'($urandom_range(0, 16383)), dy[17:0]});
    write_reg(REG_DIR_Z, {14'($urandom_range(0, 16383)), dz[17:0]});
    write_reg(REG_FACE_SEL, {16'($urandom), face});
    write_reg(REG_FACE_MOD, {15'($urandom_range(0, 32767)), 16'h0, mode});
  endtask

  function automatic tri_in_t make_tri(longint a [3], longint b [3], longint c [3],
                                       logic [15:0] face, logic last);
    tri_in_t t;
    t.v0_x = a[0][31:0]; t.v0_y = a[1][31:0]; t.v0_z = a[2][31:0];
    t.v1_x = b[0][31:0]; t.v1_y = b[1][31:0]; t.v1_z = b[2][31:0];
    t.v2_x = c[0][31:0]; t.v2_y = c[1][31:0]; t.v2_z = c[2][31:0];
    t.tri_face = face;
    t.last_tri = last;
    return t;
  endfunction

  // triangle scattered around a point on the ray, so it is often hit
  function automatic tri_in_t aimed_tri(logic [15:0] face, logic last);
    longint pt [3], a [3], b [3], c [3];
    longint along;
    int spread;
    along = $urandom_range(0, 1) ? $urandom_range(1, 40) : -longint'($urandom_range(0, 5));
    spread = $urandom_range(0, 3) == 0 ? 8 * UNIT : 2 * UNIT;
    for (int i = 0; i < 3; i++) begin
      pt[i] = ray_org[i] + ray_dir[i] * along + $signed($urandom_range(0, 511)) - 256;
      a[i] = pt[i] + $signed($urandom_range(0, 2 * spread)) - spread;
      b[i] = pt[i] + $signed($urandom_range(0, 2 * spread)) - spread;
      c[i] = pt[i] + $signed($urandom_range(0, 2 * spread)) - spread;
    end
    return make_tri(a, b, c, face, last);
  endfunction

  function automatic tri_in_t noise_tri(logic last);
    tri_in_t t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 17'($urandom)};
    t.last_tri = last;
    return t;
  endfunction

  // meshes of a few triangles each; faces mostly near the selected one
  task automatic send_meshes(int n_items, int noise_pct, int max_len);
    int sent;
    int len;
    logic [15:0] face;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      for (int k = 0; k < len; k++) begin
        face = $urandom_range(0, 2) == 0 ? sel_face
                                         : sel_face + 16'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < noise_pct) send_tri(noise_tri(k == len - 1));
        else send_tri(aimed_tri(face, k == len - 1));
      end
      sent += len;
    end
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) < 3) begin
      hold_left <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    hit_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result item hit=%0b dist=%0d",
               out_data.hit, out_data.nearest_distance);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (out_data.hit !== e.hit) begin
          $error("hit: expected %0b, got %0b", e.hit, out_data.hit);
          errors++;
        end
        if (out_data.nearest_distance !== e.nearest_distance) begin
          $error("nearest_distance: expected %0d, got %0d",
                 e.nearest_distance, out_data.nearest_distance);
          errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    longint a [3], b [3], c [3];
    // unit z ray from the origin, triangle straddling the axis at z = 5
    set_ray(0, 0, 0, 0, 0, UNIT, 16'h0005, MODE_SKIP);
    a = '{-UNIT, -UNIT, 5 * UNIT}; b = '{2 * UNIT, -UNIT, 5 * UNIT};
    c = '{-UNIT, 2 * UNIT, 5 * UNIT};
    send_tri(make_tri(a, b, c, 16'h0001, 1'b1));
    // same triangle on the skipped face, then behind the origin
    send_tri(make_tri(a, b, c, 16'h0005, 1'b0));
    a[2] = -5 * UNIT; b[2] = -5 * UNIT; c[2] = -5 * UNIT;
    send_tri(make_tri(a, b, c, 16'h0001, 1'b1));
    // parallel to the ray
    a = '{0, -UNIT, 0}; b = '{0, UNIT, 0}; c = '{0, 0, 4 * UNIT};
    send_tri(make_tri(a, b, c, 16'h0002, 1'b1));
    // extreme coordinates, largest face id, last flags
    a = '{64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF};
    b = '{-64'sh80000000, -64'sh80000000, -64'sh80000000};
    c = '{64'sh7FFFFFFF, -64'sh80000000, 0};
    send_tri(make_tri(a, b, c, 16'hFFFF, 1'b0));
    send_tri(make_tri(b, a, c, 16'h0000, 1'b1));
    send_tri(make_tri(c, b, a, 16'hFFFF, 1'b1));
    // two hits: nearer one must win
    a = '{-UNIT, -UNIT, 9 * UNIT}; b = '{2 * UNIT, -UNIT, 9 * UNIT};
    c = '{-UNIT, 2 * UNIT, 9 * UNIT};
    send_tri(make_tri(a, b, c, 16'h0003, 1'b0));
    a[2] = 3 * UNIT; b[2] = 3 * UNIT; c[2] = 3 * UNIT;
    send_tri(make_tri(a, b, c, 16'h0003, 1'b1));
    // far away hit that saturates the distance
    set_ray(0, 0, -64'sd2147483648, 0, 0, UNIT, 16'hFFFF, MODE_SKIP);
    a = '{-UNIT, -UNIT, 64'sh7FFF0000}; b = '{2 * UNIT, -UNIT, 64'sh7FFF0000};
    c = '{-UNIT, 2 * UNIT, 64'sh7FFF0000};
    send_tri(make_tri(a, b, c, 16'h0000, 1'b1));
    // only the selected face counts, minus z direction
    set_ray(0, 0, 0, 0, 0, -UNIT, 16'hFFFF, MODE_ONLY);
    a = '{-UNIT, -UNIT, -6 * UNIT}; b = '{2 * UNIT, -UNIT, -6 * UNIT};
    c = '{-UNIT, 2 * UNIT, -6 * UNIT};
    send_tri(make_tri(a, b, c, 16'h0000, 1'b1));
    send_tri(make_tri(a, b, c, 16'hFFFF, 1'b0));
    a[2] = -2 * UNIT; b[2] = -2 * UNIT; c[2] = -2 * UNIT;
    send_tri(make_tri(a, b, c, 16'hFFFF, 1'b1));
    // extreme register values with out-of-range direction patterns
    set_ray(64'sh7FFFFFFF, -64'sd2147483648, 64'sh7FFFFFFF,
            -UNIT, UNIT, 64'sh1FFFF, 16'h0000, MODE_SKIP);
    send_tri(noise_tri(1'b0));
    send_tri(aimed_tri(16'h0001, 1'b1));
    set_ray(0, 0, 0, -64'sd131072, 64'sd131071, -UNIT, 16'h0000, MODE_ONLY);
    send_tri(noise_tri(1'b1));
    send_tri(aimed_tri(16'h0000, 1'b1));
  endtask

  task automatic test_random_rays();
    longint d [3];
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 3; i++) d[i] = $signed($urandom_range(0, 2 * UNIT)) - UNIT;
      d[ph % 3] = (ph & 1) ? UNIT : -UNIT;
      no_idle = (ph == 3);
      set_ray($signed($urandom_range(0, 200 * UNIT)) - 100 * UNIT,
              $signed($urandom_range(0, 200 * UNIT)) - 100 * UNIT,
              $signed($urandom_range(0, 200 * UNIT)) - 100 * UNIT,
              d[0], d[1], d[2], 16'($urandom), ph >= 5 ? MODE_ONLY : MODE_SKIP);
      send_meshes(110, 10, 6);
    end
    no_idle = 0;
  endtask

  task automatic test_output_stall();
    set_ray(0, 0, 0, 0, 0, UNIT, 16'h0007, MODE_SKIP);
    hold_reqs++;
    no_idle = 1;
    send_meshes(60, 0, 2);
    no_idle = 0;
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, UNIT};
    sel_face = '0;
    sel_mode = MODE_SKIP;
    best_dist = DIST_MAX;
    seen_hit = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // a few meshes against the reset ray first
    send_meshes(20, 20, 4);
    test_directed();
    test_random_rays();
    test_output_stall();
    drain();
    if (errors == 0) $display("ray_triangle_nearest_hit_tb OK");
    else $display("ray_triangle_nearest_hit_tb NOT OK");
    $finish;
  end

endmodule
